// ===== rtl/substring_first_match_search_assert.svh =====
// assertion macros for the substring search block
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_ASSERT_SVH

// checked out of reset only
`define SFMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define SFMS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sfms_pkg.sv =====
// shared types and constants for the substring search block
`timescale 1ns / 1ps

package sfms_pkg;

  localparam int unsigned MaxLenDefault = 256;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned PosW          = 9;

  localparam logic KindHay    = 1'b0;
  localparam logic KindNeedle = 1'b1;

  typedef struct packed {
    logic             kind;
    logic             has_byte;
    logic [ByteW-1:0] char_byte;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            overflow;
  } out_t;

  typedef struct packed {
    logic hay;
    logic ndl;
  } wr_en_t;

endpackage

// ===== rtl/sfms_ram.sv =====
// generic single write, single registered read ram
`timescale 1ns / 1ps

module sfms_ram #(
  parameter int unsigned Width = sfms_pkg::ByteW,
  parameter int unsigned Depth = sfms_pkg::MaxLenDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfms_ctrl.sv =====
// load control, scan sequencer and byte comparator
`timescale 1ns / 1ps

module sfms_ctrl #(
  parameter int unsigned MaxLen = sfms_pkg::MaxLenDefault,
  localparam int unsigned AW = (MaxLen > 1) ? $clog2(MaxLen) : 1,
  localparam int unsigned LW = $clog2(MaxLen + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  sfms_pkg::in_t            in_data_i,
  output sfms_pkg::wr_en_t         wr_en_o,
  output logic [AW-1:0]            hay_waddr_o,
  output logic [AW-1:0]            ndl_waddr_o,
  output logic [sfms_pkg::ByteW-1:0] wdata_o,
  output logic [AW-1:0]            hay_raddr_o,
  output logic [AW-1:0]            ndl_raddr_o,
  input  logic [sfms_pkg::ByteW-1:0] hay_rdata_i,
  input  logic [sfms_pkg::ByteW-1:0] ndl_rdata_i,
  input  logic                     out_free_i,
  output logic                     res_valid_o,
  output sfms_pkg::out_t           res_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [LW-1:0]             hay_len_q, hay_len_d;
  logic [LW-1:0]             ndl_len_q, ndl_len_d;
  logic                      drop_q, drop_d;
  logic [AW-1:0]             s_q, s_d;
  logic [AW-1:0]             j_q, j_d;
  logic [LW-1:0]             lim_q, lim_d;
  logic [sfms_pkg::PosW-1:0] pos_q, pos_d;

  logic          accept;
  logic          hay_full;
  logic          ndl_full;
  logic          match;
  logic          j_last;
  logic          s_last;
  logic [LW-1:0] s_inc;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign hay_full   = (hay_len_q == LW'(MaxLen));
  assign ndl_full   = (ndl_len_q == LW'(MaxLen));

  assign wr_en_o.hay = accept && in_data_i.has_byte &&
                       (in_data_i.kind == sfms_pkg::KindHay) && !hay_full;
  assign wr_en_o.ndl = accept && in_data_i.has_byte &&
                       (in_data_i.kind == sfms_pkg::KindNeedle) && !ndl_full;
  assign hay_waddr_o = hay_len_q[AW-1:0];
  assign ndl_waddr_o = ndl_len_q[AW-1:0];
  assign wdata_o     = in_data_i.char_byte;

  // compare unit
  assign match  = (hay_rdata_i == ndl_rdata_i);
  assign j_last = ((LW'(j_q) + LW'(1)) == ndl_len_q);
  assign s_last = (LW'(s_q) == lim_q);
  assign s_inc  = LW'(s_q) + LW'(1);

  // reads are issued from the next offsets so data lines up with the scan state
  assign hay_raddr_o = s_d + j_d;
  assign ndl_raddr_o = j_d;

  always_comb begin
    state_d     = state_q;
    hay_len_d   = hay_len_q;
    ndl_len_d   = ndl_len_q;
    drop_d      = drop_q;
    s_d         = s_q;
    j_d         = j_q;
    lim_d       = lim_q;
    pos_d       = pos_q;
    res_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (wr_en_o.hay) begin
            hay_len_d = hay_len_q + LW'(1);
          end
          if (wr_en_o.ndl) begin
            ndl_len_d = ndl_len_q + LW'(1);
          end
          if (in_data_i.has_byte &&
              (((in_data_i.kind == sfms_pkg::KindHay) && hay_full) ||
               ((in_data_i.kind == sfms_pkg::KindNeedle) && ndl_full))) begin
            drop_d = 1'b1;
          end
          if ((in_data_i.kind == sfms_pkg::KindNeedle) && in_data_i.last) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        s_d = '0;
        j_d = '0;
        if ((ndl_len_q == '0) || (ndl_len_q > hay_len_q)) begin
          pos_d   = '0;
          state_d = StDone;
        end else begin
          lim_d   = hay_len_q - ndl_len_q;
          state_d = StScan;
        end
      end
      StScan: begin
        if (match && j_last) begin
          pos_d   = sfms_pkg::PosW'(s_inc);
          state_d = StDone;
        end else if (match) begin
          j_d = j_q + AW'(1);
        end else if (s_last) begin
          pos_d   = '0;
          state_d = StDone;
        end else begin
          s_d = s_q + AW'(1);
          j_d = '0;
        end
      end
      StDone: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          hay_len_d   = '0;
          ndl_len_d   = '0;
          drop_d      = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign res_o.position = pos_q;
  assign res_o.overflow = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      hay_len_q <= '0;
      ndl_len_q <= '0;
      drop_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      hay_len_q <= hay_len_d;
      ndl_len_q <= ndl_len_d;
      drop_q    <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    j_q   <= j_d;
    lim_q <= lim_d;
    pos_q <= pos_d;
  end

endmodule

// ===== rtl/substring_first_match_search.sv =====
// top level of the first match substring search block
//
//  channel | dir | handshake             | beat
//  in      | in  | in_valid_i/in_ready_o  | sfms_pkg::in_t (kind, has_byte, char_byte, last)
//  out     | out | out_valid_o/out_ready_i | sfms_pkg::out_t (position, overflow)
//
// loading takes one beat per cycle while idle; a needle beat with last set starts the scan
// scan: a check state, then one byte compare per cycle (at most (hay-needle+1)*needle)
// one shared byte comparator reads both stores through one read port each
// reset needs no clearing pass; store data is only compared below the stored lengths
// one result may wait in the output register while loading goes on
// a second result holds the scan in its last state and stalls the input
`timescale 1ns / 1ps

module substring_first_match_search #(
  parameter int unsigned MaxLen = sfms_pkg::MaxLenDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sfms_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sfms_pkg::out_t out_data_o
);

  localparam int unsigned AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  sfms_pkg::wr_en_t           wr_en;
  logic [AW-1:0]              hay_waddr, ndl_waddr, hay_raddr, ndl_raddr;
  logic [sfms_pkg::ByteW-1:0] wdata, hay_rdata, ndl_rdata;
  logic                       out_free;
  logic                       res_valid;
  sfms_pkg::out_t             res;
  logic                       out_valid_q;
  sfms_pkg::out_t             out_data_q;

  sfms_ram #(
    .Width (sfms_pkg::ByteW),
    .Depth (MaxLen)
  ) u_hay_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en.hay),
    .waddr_i (hay_waddr),
    .wdata_i (wdata),
    .raddr_i (hay_raddr),
    .rdata_o (hay_rdata)
  );

  sfms_ram #(
    .Width (sfms_pkg::ByteW),
    .Depth (MaxLen)
  ) u_ndl_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en.ndl),
    .waddr_i (ndl_waddr),
    .wdata_i (wdata),
    .raddr_i (ndl_raddr),
    .rdata_o (ndl_rdata)
  );

  sfms_ctrl #(
    .MaxLen (MaxLen)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .wr_en_o     (wr_en),
    .hay_waddr_o (hay_waddr),
    .ndl_waddr_o (ndl_waddr),
    .wdata_o     (wdata),
    .hay_raddr_o (hay_raddr),
    .ndl_raddr_o (ndl_raddr),
    .hay_rdata_i (hay_rdata),
    .ndl_rdata_i (ndl_rdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/sfms_checker.sv =====
// port level checker for the substring search block, with its bind
`timescale 1ns / 1ps
`include "substring_first_match_search_assert.svh"

module sfms_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input sfms_pkg::in_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i
);

  logic in_acc;
  logic search_acc;

  assign in_acc     = in_valid_i && in_ready_o;
  assign search_acc = in_acc && (in_data_i.kind == sfms_pkg::KindNeedle) && in_data_i.last;

  `SFMS_ASSERT_RST(a_rst_no_result, !rst_ni |-> !out_valid_o, "result beat during reset")
  `SFMS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result beat dropped")
  `SFMS_ASSERT(a_search_stalls, search_acc |=> !in_ready_o, "input taken during scan")
  `SFMS_ASSERT(a_load_ready, in_acc && !search_acc |=> in_ready_o, "load beat stalled input")
  `SFMS_ASSERT(a_result_after_scan, $rose(out_valid_o) |-> !$past(in_ready_o), "result without scan")

endmodule

bind substring_first_match_search sfms_checker u_sfms_checker (.*);
